// File: hw/rtl/disk_scan_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disk scan scheduler
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISK_SCAN_SCHEDULER_TOP_MACROS_SVH
`define DISK_SCAN_SCHEDULER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("disk_scan_scheduler: same-cycle check failed");
// next-cycle implication
`define DSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("disk_scan_scheduler: next-cycle check failed");
`else
`define DSS_ASSERT_IMP(lbl, ante, cons)
`define DSS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Widths, entry type, cell control and sort key for the disk scan scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int MAX_REQ  = 64;
  localparam int TRACK_W  = 13;
  localparam int SECTOR_W = 14;
  localparam int KEY_W    = TRACK_W + 1;
  localparam int CNT_W    = $clog2(MAX_REQ + 1);
  localparam int SEEK_W   = 15;
  localparam int TOTAL_W  = 21;
  localparam int STEP_W   = $clog2(TOTAL_W + 1);

  localparam logic [TRACK_W-1:0] HEAD_START_RST = TRACK_W'(2500);

  typedef struct packed {
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic               parity;     // odd/even round of the transposition sort
    logic [TRACK_W-1:0] head_start;
  } cell_ctrl_t;

  // Ascending key gives the elevator order: upward sweep first in rising
  // track order, then the downward sweep in falling track order.
  function automatic logic [KEY_W-1:0] sort_key(input logic [TRACK_W-1:0] track,
                                                input logic [TRACK_W-1:0] head);
    logic down;
    down = track < head;
    return {down, down ? ~track : track};
  endfunction

endpackage

// File: hw/rtl/disk_scan_scheduler_top.sv
// ----------------------------------------------------------------------------
// disk_scan_scheduler_top
// Elevator (SCAN) disk request scheduler built on a chain of sorting cells.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle, while in_stall_o is low, into a 64-slot
// chain; a request beyond the capacity is dropped and the batch reports
// overflow. The request marked last starts the schedule: rounds of odd/even
// compare-exchange in the chain put the batch into elevator order around
// head_start, then one result per cycle leaves slot 0 while the output is
// taken. The final result waits for the bit-serial divider that forms the
// mean seek time. No input is taken from the last request until the final
// result is registered. The chain needs no clearing after reset.
// head_start should only be written between batches.
`include "disk_scan_scheduler_top_macros.svh"

module disk_scan_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dss_pkg::TRACK_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dss_pkg::TRACK_W-1:0]  track_i,
  input  logic [dss_pkg::SECTOR_W-1:0] sector_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dss_pkg::TRACK_W-1:0]  served_track_o,
  output logic [dss_pkg::SECTOR_W-1:0] served_sector_o,
  output logic [dss_pkg::TRACK_W-1:0]  move_distance_o,
  output logic [dss_pkg::SEEK_W-1:0]   seek_time_o,
  output logic [dss_pkg::SEEK_W-1:0]   average_seek_o,
  output logic                         overflow_o,
  output logic                         final_res_o
);
  import dss_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT,
    ST_DIVIDE
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    count_q;
  logic                dropped_q;
  logic [CNT_W-1:0]    round_q;
  logic [CNT_W-1:0]    emit_q;
  logic [TRACK_W-1:0]  head_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TRACK_W-1:0]  head_start_q;

  logic                out_valid_q;
  logic [TRACK_W-1:0]  out_track_q;
  logic [SECTOR_W-1:0] out_sector_q;
  logic [TRACK_W-1:0]  out_dist_q;
  logic [SEEK_W-1:0]   out_seek_q;
  logic [SEEK_W-1:0]   out_avg_q;
  logic                out_ovf_q;
  logic                out_final_q;

  logic                in_take;
  logic                has_room;
  logic                out_free;
  logic                emit_fire;
  logic                last_emit;
  logic [TRACK_W-1:0]  move_dist;
  logic [SEEK_W-1:0]   seek;
  logic [TOTAL_W-1:0]  total_sum;
  logic                div_done;
  logic [TOTAL_W-1:0]  div_quo;

  cell_ctrl_t          ctrl;
  entry_t              load_data;
  entry_t              cell_entry [MAX_REQ];
  logic                cell_lt    [MAX_REQ];
  entry_t              head_entry;

  assign in_stall_o = state_q != ST_LOAD;
  assign in_take    = in_valid_i && (state_q == ST_LOAD);
  assign has_room   = count_q < CNT_W'(MAX_REQ);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign last_emit  = emit_q == (count_q - CNT_W'(1));

  assign head_entry = cell_entry[0];
  assign move_dist  = (head_entry.track >= head_q) ? head_entry.track - head_q
                                                   : head_q - head_entry.track;
  assign seek       = SEEK_W'(move_dist) + SEEK_W'(head_entry.sector);
  assign total_sum  = total_q + TOTAL_W'(seek);

  assign load_data.track  = track_i;
  assign load_data.sector = sector_i;

  always_comb begin
    ctrl.parity     = round_q[0];
    ctrl.head_start = head_start_q;
    if (in_take && has_room)     ctrl.op = CELL_LOAD;
    else if (state_q == ST_SORT) ctrl.op = CELL_SORT;
    else if (emit_fire)          ctrl.op = CELL_SHIFT;
    else                         ctrl.op = CELL_HOLD;
  end

  for (genvar i = 0; i < MAX_REQ; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   right_lt;
    logic   lt_en;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign lt_en  = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign lt_en  = CNT_W'(i) < count_q;
    end

    if (i == MAX_REQ - 1) begin : g_last
      assign right_e  = '0;
      assign right_lt = 1'b0;
    end else begin : g_inner
      assign right_e  = cell_entry[i+1];
      assign right_lt = cell_lt[i+1];
    end

    dss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .load_en_i   (count_q == CNT_W'(i)),
      .pair_right_i(1'(i % 2)),
      .lt_en_i     (lt_en),
      .load_data_i (load_data),
      .left_i      (left_e),
      .right_i     (right_e),
      .right_lt_i  (right_lt),
      .entry_o     (cell_entry[i]),
      .lt_o        (cell_lt[i])
    );
  end

  dss_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (emit_fire && last_emit),
    .dividend_i(total_sum),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      round_q      <= '0;
      emit_q       <= '0;
      head_q       <= '0;
      total_q      <= '0;
      head_start_q <= HEAD_START_RST;
      out_valid_q  <= 1'b0;
      out_track_q  <= '0;
      out_sector_q <= '0;
      out_dist_q   <= '0;
      out_seek_q   <= '0;
      out_avg_q    <= '0;
      out_ovf_q    <= 1'b0;
      out_final_q  <= 1'b0;
    end else begin
      if (cfg_we_i) head_start_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_LOAD: begin
          if (in_take) begin
            if (has_room) count_q <= count_q + CNT_W'(1);
            else          dropped_q <= 1'b1;
            if (last_i) begin
              state_q <= ST_SORT;
              round_q <= '0;
            end
          end
        end
        ST_SORT: begin
          round_q <= round_q + CNT_W'(1);
          if (round_q == count_q - CNT_W'(1)) begin
            state_q <= ST_EMIT;
            emit_q  <= '0;
            head_q  <= head_start_q;
            total_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_track_q  <= head_entry.track;
            out_sector_q <= head_entry.sector;
            out_dist_q   <= move_dist;
            out_seek_q   <= seek;
            out_ovf_q    <= dropped_q;
            out_avg_q    <= '0;
            head_q       <= head_entry.track;
            total_q      <= total_sum;
            if (last_emit) begin
              // final result is held back until the mean is ready
              out_valid_q <= 1'b0;
              out_final_q <= 1'b1;
              state_q     <= ST_DIVIDE;
            end else begin
              out_valid_q <= 1'b1;
              out_final_q <= 1'b0;
              emit_q      <= emit_q + CNT_W'(1);
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            out_avg_q   <= div_quo[SEEK_W-1:0];
            out_valid_q <= 1'b1;
            count_q     <= '0;
            dropped_q   <= 1'b0;
            state_q     <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign served_track_o  = out_track_q;
  assign served_sector_o = out_sector_q;
  assign move_distance_o = out_dist_q;
  assign seek_time_o     = out_seek_q;
  assign average_seek_o  = out_avg_q;
  assign overflow_o      = out_ovf_q;
  assign final_res_o     = out_final_q;

  `DSS_ASSERT_IMP(a_sort_has_requests, state_q == ST_SORT, count_q != '0)
  `DSS_ASSERT_IMP(a_emit_in_range, state_q == ST_EMIT, emit_q < count_q)
  `DSS_ASSERT_IMP(a_divide_holds_output, state_q == ST_DIVIDE, !out_valid_q)
  `DSS_ASSERT_IMP(a_avg_only_final, out_valid_q && !out_final_q, out_avg_q == '0)

endmodule

// File: hw/rtl/dss_cell.sv
// ----------------------------------------------------------------------------
// dss_cell
// One slot of the request chain: loads, compare-exchanges with a neighbor
// during the sort, and shifts toward slot 0 while results are drained.
// ----------------------------------------------------------------------------
module dss_cell (
  input  logic                clk_i,
  input  dss_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_en_i,
  input  logic                pair_right_i,
  input  logic                lt_en_i,      // this slot and its left neighbor hold requests
  input  dss_pkg::entry_t     load_data_i,
  input  dss_pkg::entry_t     left_i,
  input  dss_pkg::entry_t     right_i,
  input  logic                right_lt_i,
  output dss_pkg::entry_t     entry_o,
  output logic                lt_o
);
  import dss_pkg::*;

  entry_t entry_q, entry_d;

  // strict compare keeps equal tracks in arrival order
  assign lt_o = lt_en_i &&
                (sort_key(entry_q.track, ctrl_i.head_start) <
                 sort_key(left_i.track, ctrl_i.head_start));

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        if (load_en_i) entry_d = load_data_i;
      end
      CELL_SORT: begin
        if (pair_right_i == ctrl_i.parity) begin
          if (right_lt_i) entry_d = right_i;
        end else if (lt_o) begin
          entry_d = left_i;
        end
      end
      CELL_SHIFT: entry_d = right_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hw/rtl/dss_div.sv
// ----------------------------------------------------------------------------
// dss_div
// Restoring divider, one quotient bit per cycle, for the mean seek time.
// ----------------------------------------------------------------------------
`include "disk_scan_scheduler_top_macros.svh"

module dss_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dss_pkg::TOTAL_W-1:0] dividend_i,
  input  logic [dss_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [dss_pkg::TOTAL_W-1:0] quotient_o
);
  import dss_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   div_q;
  logic [CNT_W-1:0]   rem_q;
  logic [TOTAL_W-1:0] quo_q;

  logic [CNT_W:0]     trial;
  logic               fits;

  assign trial = {rem_q, quo_q[TOTAL_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        div_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q  <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
        quo_q  <= {quo_q[TOTAL_W-2:0], fits};
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(TOTAL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `DSS_ASSERT_NXT(a_div_busy_after_start, start_i, busy_q)
  `DSS_ASSERT_IMP(a_div_done_idle, done_q, !busy_q)
  `DSS_ASSERT_NXT(a_div_done_pulse, done_q, !done_q)

endmodule
